/* design/crth_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crth_pkg
// Shared types and constants for the closest ray/triangle hit block.
// ----------------------------------------------------------------------------
package crth_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int FACE_ID_BITS = 20;
    localparam int WIDE         = 128;
    localparam int QBITS        = 64;
    localparam int NSTEP        = 25;

    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X = 3'd3;
    localparam logic [2:0] REG_DIR_Y = 3'd4;
    localparam logic [2:0] REG_DIR_Z = 3'd5;
    localparam logic [2:0] REG_EPS   = 3'd6;
    localparam logic [2:0] REG_SELF  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

/* design/crth_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crth_divider
// Restoring divider, one quotient bit per cycle; low QBITS bits plus overflow.
// ----------------------------------------------------------------------------
module crth_divider
    import crth_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE-1:0]   num,
    input  logic [WIDE-1:0]   den,
    output div_ctl_t          ctl,
    output logic [QBITS:0]    quo
);

    logic [WIDE-1:0] num_reg, num_next;
    logic [WIDE:0]   rem_reg, rem_next;
    logic [QBITS:0]  quo_reg, quo_next;
    logic            ovf_reg, ovf_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [WIDE:0]   shifted;
    logic [WIDE:0]   diff;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[WIDE-1:0], num_reg[WIDE-1]};
        diff      = shifted - {1'b0, den};
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
            cnt_next  = 8'(WIDE);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[WIDE-2:0], 1'b0};
            // quotient bits above QBITS fold into a sticky overflow
            ovf_next = ovf_reg | quo_reg[QBITS];
            if (!diff[WIDE])
            begin
                rem_next = diff;
                quo_next = {quo_reg[QBITS-1:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[QBITS-1:0], 1'b0};
            end
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quo       = {ovf_reg | quo_reg[QBITS], quo_reg[QBITS-1:0]};

endmodule

/* design/closest_ray_triangle_hit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_ray_triangle_hit
// Moller-Trumbore ray/triangle test with closest-hit tracking.
// ----------------------------------------------------------------------------
// Usage: write the ray through cfg_we/cfg_index/cfg_data while idle, then
// stream triangle requests on in_valid/in_stall. in_stall stays high while a
// triangle is being tested. Each triangle runs 25 multiply-accumulate steps
// on one shared 33x33 multiplier, each step working through four 32-bit
// slices of the wide operand, then a check state and, when the tests pass,
// a bit-serial divider for t. A new triangle is accepted only after the
// current one is done, so the divider sets the worst-case rate. A request
// marked last_triangle goes on from the update state to an output state
// that raises out_valid with hit_found, hit_face and hit_distance. The
// result holds while out_stall is high; new triangles are still taken, and
// only the next result waits for it. Reset restores the default ray and
// clears the closest hit.
// ----------------------------------------------------------------------------
module closest_ray_triangle_hit
    import crth_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [31:0]      v0_x,
    input  logic signed [31:0]      v0_y,
    input  logic signed [31:0]      v0_z,
    input  logic signed [31:0]      v1_x,
    input  logic signed [31:0]      v1_y,
    input  logic signed [31:0]      v1_z,
    input  logic signed [31:0]      v2_x,
    input  logic signed [31:0]      v2_y,
    input  logic signed [31:0]      v2_z,
    input  logic [FACE_ID_BITS-1:0] tri_face_id,
    input  logic                    last_triangle,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    hit_found,
    output logic [FACE_ID_BITS-1:0] hit_face,
    output logic [30:0]             hit_distance
);

    // configuration
    logic signed [31:0] org_reg [3];
    logic signed [31:0] dir_reg [3];
    logic [15:0]        eps_reg;
    logic [30:0]        self_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= 32'sd1 <<< FRAC_BITS;
            dir_reg[1] <= '0;
            dir_reg[2] <= '0;
            eps_reg    <= 16'd1;
            self_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORG_X: org_reg[0] <= cfg_data;
                REG_ORG_Y: org_reg[1] <= cfg_data;
                REG_ORG_Z: org_reg[2] <= cfg_data;
                REG_DIR_X: dir_reg[0] <= cfg_data;
                REG_DIR_Y: dir_reg[1] <= cfg_data;
                REG_DIR_Z: dir_reg[2] <= cfg_data;
                REG_EPS:   eps_reg    <= cfg_data[15:0];
                REG_SELF:  self_reg   <= cfg_data[30:0];
                default:   ;
            endcase
        end
    end

    // operand vectors: e1, e2, s and d 33-bit signed; p and q WIDE-bit signed
    logic signed [32:0] e1_reg [3];
    logic signed [32:0] e2_reg [3];
    logic signed [32:0] s_reg  [3];
    logic signed [32:0] d_reg  [3];
    logic signed [WIDE-1:0] p_reg [3];
    logic signed [WIDE-1:0] q_reg [3];
    logic signed [WIDE-1:0] det_reg, un_reg, vn_reg, tn_reg;
    logic signed [WIDE-1:0] epsdet_reg;
    logic signed [WIDE-1:0] acc_reg, acc_next;
    logic [FACE_ID_BITS-1:0] face_reg;
    logic                    last_reg;

    state_t state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic [1:0] part_reg, part_next;

    logic [31:0]             best_d_reg, best_d_next;
    logic [FACE_ID_BITS-1:0] best_f_reg, best_f_next;
    logic                    any_reg, any_next;
    logic                    ov_reg, ov_next;
    logic                    of_reg, of_next;
    logic [FACE_ID_BITS-1:0] oface_reg, oface_next;
    logic [30:0]             odist_reg, odist_next;

    // shared multiplier operand selection
    logic signed [32:0]     ma;
    logic signed [WIDE-1:0] mb;
    logic                   msub, mclr;
    logic signed [32:0]     mchunk;
    logic signed [65:0]     pp;
    logic signed [WIDE-1:0] prod;

    // absolute-value normalization and bound checks
    logic                   negdet;
    logic signed [WIDE-1:0] adet, aun, avn, atn;
    logic signed [WIDE-1:0] epsw, highb;
    logic signed [WIDE-1:0] us, vs, uvs, ts;
    logic                   pass;

    // step plan: cross p = d x e2 (6), det = e1.p, un = s.p (6),
    // q = s x e1 (6), vn = d.q, tn = e2.q (6), then eps * |det|
    always_comb
    begin
        ma = '0; mb = '0; msub = 1'b0; mclr = 1'b0;
        unique case (step_reg)
            6'd0:  begin ma = d_reg[1]; mb = WIDE'(e2_reg[2]); mclr = 1'b1; end
            6'd1:  begin ma = d_reg[2]; mb = WIDE'(e2_reg[1]); msub = 1'b1; end
            6'd2:  begin ma = d_reg[2]; mb = WIDE'(e2_reg[0]); mclr = 1'b1; end
            6'd3:  begin ma = d_reg[0]; mb = WIDE'(e2_reg[2]); msub = 1'b1; end
            6'd4:  begin ma = d_reg[0]; mb = WIDE'(e2_reg[1]); mclr = 1'b1; end
            6'd5:  begin ma = d_reg[1]; mb = WIDE'(e2_reg[0]); msub = 1'b1; end
            6'd6:  begin ma = e1_reg[0]; mb = p_reg[0]; mclr = 1'b1; end
            6'd7:  begin ma = e1_reg[1]; mb = p_reg[1]; end
            6'd8:  begin ma = e1_reg[2]; mb = p_reg[2]; end
            6'd9:  begin ma = s_reg[0]; mb = p_reg[0]; mclr = 1'b1; end
            6'd10: begin ma = s_reg[1]; mb = p_reg[1]; end
            6'd11: begin ma = s_reg[2]; mb = p_reg[2]; end
            6'd12: begin ma = s_reg[1]; mb = WIDE'(e1_reg[2]); mclr = 1'b1; end
            6'd13: begin ma = s_reg[2]; mb = WIDE'(e1_reg[1]); msub = 1'b1; end
            6'd14: begin ma = s_reg[2]; mb = WIDE'(e1_reg[0]); mclr = 1'b1; end
            6'd15: begin ma = s_reg[0]; mb = WIDE'(e1_reg[2]); msub = 1'b1; end
            6'd16: begin ma = s_reg[0]; mb = WIDE'(e1_reg[1]); mclr = 1'b1; end
            6'd17: begin ma = s_reg[1]; mb = WIDE'(e1_reg[0]); msub = 1'b1; end
            6'd18: begin ma = d_reg[0]; mb = q_reg[0]; mclr = 1'b1; end
            6'd19: begin ma = d_reg[1]; mb = q_reg[1]; end
            6'd20: begin ma = d_reg[2]; mb = q_reg[2]; end
            6'd21: begin ma = e2_reg[0]; mb = q_reg[0]; mclr = 1'b1; end
            6'd22: begin ma = e2_reg[1]; mb = q_reg[1]; end
            6'd23: begin ma = e2_reg[2]; mb = q_reg[2]; end
            6'd24: begin ma = $signed({17'd0, eps_reg}); mb = adet; mclr = 1'b1; end
            default: ;
        endcase
    end

    // wide operand taken 32 bits per cycle, top slice signed, low ones not
    always_comb
    begin
        unique case (part_reg)
            2'd0: mchunk = $signed({1'b0, mb[31:0]});
            2'd1: mchunk = $signed({1'b0, mb[63:32]});
            2'd2: mchunk = $signed({1'b0, mb[95:64]});
            2'd3: mchunk = $signed({mb[WIDE-1], mb[WIDE-1:96]});
        endcase
    end

    assign pp   = ma * mchunk;
    assign prod = WIDE'(pp) << {part_reg, 5'd0};

    always_comb
    begin
        if (mclr && part_reg == 2'd0)
            acc_next = msub ? -prod : prod;
        else
            acc_next = msub ? acc_reg - prod : acc_reg + prod;
    end

    always_comb
    begin
        negdet = det_reg[WIDE-1];
        adet   = negdet ? -det_reg : det_reg;
        aun    = negdet ? -un_reg : un_reg;
        avn    = negdet ? -vn_reg : vn_reg;
        atn    = negdet ? -tn_reg : tn_reg;
        epsw   = WIDE'($unsigned(eps_reg));
        // (1 + eps) * |det| as eps * |det| plus |det| in Q16.16
        highb  = epsdet_reg + (adet <<< FRAC_BITS);
        us     = aun <<< FRAC_BITS;
        vs     = avn <<< FRAC_BITS;
        uvs    = (aun + avn) <<< FRAC_BITS;
        ts     = atn <<< FRAC_BITS;
        pass   = ($unsigned(adet) > $unsigned(epsw << (2 * FRAC_BITS)))
                 && !(us < -epsdet_reg) && !(us > highb)
                 && !(vs < -epsdet_reg) && !(uvs > highb)
                 && (ts > epsdet_reg);
    end

    logic            dstart;
    div_ctl_t        dctl;
    logic [QBITS:0]  dquo;
    logic [31:0]     tval;

    crth_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (ts),
        .den   (adet),
        .ctl   (dctl),
        .quo   (dquo)
    );

    assign tval = (dquo[QBITS:31] != '0) ? 32'h7FFF_FFFF : {1'b0, dquo[30:0]};

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        part_next   = part_reg;
        dstart      = 1'b0;
        best_d_next = best_d_reg;
        best_f_next = best_f_reg;
        any_next    = any_reg;
        ov_next     = ov_reg;
        of_next     = of_reg;
        oface_next  = oface_reg;
        odist_next  = odist_reg;
        in_stall    = 1'b1;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_MUL;
                    step_next  = '0;
                    part_next  = '0;
                end
            end
            ST_MUL:
            begin
                part_next = part_reg + 2'd1;
                if (part_reg == 2'd3)
                begin
                    step_next = step_reg + 6'd1;
                    if (step_reg == 6'(NSTEP - 1))
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (pass)
                begin
                    dstart     = 1'b1;
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_UPDATE;
            end
            ST_DIV:
            begin
                if (dctl.done)
                begin
                    if ({1'b0, self_reg} < tval && tval < best_d_reg)
                    begin
                        best_d_next = tval;
                        best_f_next = face_reg;
                        any_next    = 1'b1;
                    end
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                // wait while the previous result is still held downstream
                if (!ov_reg || !out_stall)
                begin
                    ov_next     = 1'b1;
                    of_next     = any_reg;
                    oface_next  = any_reg ? best_f_reg : '0;
                    odist_next  = any_reg ? best_d_reg[30:0] : '0;
                    best_d_next = '1;
                    best_f_next = '0;
                    any_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            part_reg   <= '0;
            best_d_reg <= '1;
            best_f_reg <= '0;
            any_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            part_reg   <= part_next;
            best_d_reg <= best_d_next;
            best_f_reg <= best_f_next;
            any_reg    <= any_next;
            ov_reg     <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        of_reg    <= of_next;
        oface_reg <= oface_next;
        odist_reg <= odist_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            e1_reg[0] <= 33'(v1_x) - 33'(v0_x);
            e1_reg[1] <= 33'(v1_y) - 33'(v0_y);
            e1_reg[2] <= 33'(v1_z) - 33'(v0_z);
            e2_reg[0] <= 33'(v2_x) - 33'(v0_x);
            e2_reg[1] <= 33'(v2_y) - 33'(v0_y);
            e2_reg[2] <= 33'(v2_z) - 33'(v0_z);
            s_reg[0]  <= 33'(org_reg[0]) - 33'(v0_x);
            s_reg[1]  <= 33'(org_reg[1]) - 33'(v0_y);
            s_reg[2]  <= 33'(org_reg[2]) - 33'(v0_z);
            d_reg[0]  <= 33'(dir_reg[0]);
            d_reg[1]  <= 33'(dir_reg[1]);
            d_reg[2]  <= 33'(dir_reg[2]);
            face_reg  <= tri_face_id;
            last_reg  <= last_triangle;
        end
        if (state_reg == ST_MUL)
        begin
            acc_reg <= acc_next;
            if (part_reg == 2'd3)
            begin
                unique case (step_reg)
                    6'd1:  p_reg[0]   <= acc_next;
                    6'd3:  p_reg[1]   <= acc_next;
                    6'd5:  p_reg[2]   <= acc_next;
                    6'd8:  det_reg    <= acc_next;
                    6'd11: un_reg     <= acc_next;
                    6'd13: q_reg[0]   <= acc_next;
                    6'd15: q_reg[1]   <= acc_next;
                    6'd17: q_reg[2]   <= acc_next;
                    6'd20: vn_reg     <= acc_next;
                    6'd23: tn_reg     <= acc_next;
                    6'd24: epsdet_reg <= acc_next;
                    default: ;
                endcase
            end
        end
    end

    assign out_valid    = ov_reg;
    assign hit_found    = of_reg;
    assign hit_face     = oface_reg;
    assign hit_distance = odist_reg;

endmodule
